// ===== design/dqsb_pkg.sv =====
// dqsb_pkg: shared types, codes and helpers for the dual queue shared buffer
// used by dqsb_ctrl, dqsb_datapath and dual_queue_shared_buffer; no dependencies
`timescale 1ns / 1ps

package dqsb_pkg;

  // request opcodes
  localparam logic [2:0] OP_PUSH_A = 3'd0;
  localparam logic [2:0] OP_PUSH_B = 3'd1;
  localparam logic [2:0] OP_POP_A  = 3'd2;
  localparam logic [2:0] OP_POP_B  = 3'd3;
  localparam logic [2:0] OP_LIST_A = 3'd4;
  localparam logic [2:0] OP_LIST_B = 3'd5;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // coarse operation class
  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_LIST = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;      // latch the incoming request
    logic    push;         // write the value and advance the rear pointer
    logic    fail;         // load an error result
    status_t fail_status;
    logic    start;        // cursor to the front of the selected queue
    logic    rd_en;        // read the buffer at the cursor
    logic    load_data;    // load the read data as an ok result
    logic    advance;      // step the cursor toward the rear
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  last;
  } dp_stat_t;

  function automatic kind_t op_kind(input logic [2:0] op);
    kind_t k;
    case (op)
      OP_PUSH_A, OP_PUSH_B: k = KIND_PUSH;
      OP_POP_A, OP_POP_B:   k = KIND_POP;
      OP_LIST_A, OP_LIST_B: k = KIND_LIST;
      default:              k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== design/dqsb_ram.sv =====
// dqsb_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dqsb_ctrl.sv =====
// dqsb_ctrl: request sequencer for the dual queue shared buffer
// depends on dqsb_pkg
`timescale 1ns / 1ps

module dqsb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dqsb_pkg::dp_stat_t  stat,
  output dqsb_pkg::ctrl_cmd_t cmd
);
  import dqsb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_FETCH = 5'b00100,
    S_READ  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.fail_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.kind)
          KIND_PUSH: begin
            if (stat.full) begin
              cmd.fail        = 1'b1;
              cmd.fail_status = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = S_OUT;
          end
          KIND_POP, KIND_LIST: begin
            if (stat.empty) begin
              cmd.fail        = 1'b1;
              cmd.fail_status = ST_UNDERFLOW;
              state_next      = S_OUT;
            end else begin
              cmd.start  = 1'b1;
              state_next = S_FETCH;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.load_data = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.kind == KIND_LIST && !stat.last) begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/dqsb_datapath.sv =====
// dqsb_datapath: queue pointers, shared buffer and result register
// depends on dqsb_pkg and dqsb_ram
`timescale 1ns / 1ps

module dqsb_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          in_opcode,
  input  logic [31:0]         in_value,
  input  dqsb_pkg::ctrl_cmd_t cmd,
  output dqsb_pkg::dp_stat_t  stat,
  output logic [31:0]         out_value,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import dqsb_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [PW-1:0] PTR_END  = PW'(DEPTH);
  localparam logic [PW-1:0] PTR_TOP  = PW'(DEPTH - 1);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);

  logic [2:0]    op;
  logic [31:0]   value;
  logic          a_valid;
  logic [PW-1:0] head_a, tail_a, head_b, tail_b;
  logic [PW-1:0] cursor;
  logic          sel_b;
  kind_t         kind;

  logic          b_empty;
  logic [PW-1:0] a_top, b_bottom, b_tail_new;
  logic          full;
  logic [PW-1:0] tail_sel;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   rd_data;

  assign sel_b = op[0];
  assign kind  = op_kind(op);

  // occupancy and next rear slots
  assign b_empty    = (head_b == PTR_END);
  assign a_top      = a_valid ? (tail_a + PTR_ONE) : '0;
  assign b_bottom   = b_empty ? PTR_END : tail_b;
  assign full       = (a_top >= b_bottom);
  assign b_tail_new = b_empty ? PTR_TOP : (tail_b - PTR_ONE);
  assign tail_sel   = sel_b ? tail_b : tail_a;

  assign stat.kind  = kind;
  assign stat.full  = full;
  assign stat.empty = sel_b ? b_empty : !a_valid;
  assign stat.last  = out_last;

  // buffer write on a push that fits
  assign wr_en   = cmd.push;
  assign wr_addr = sel_b ? b_tail_new[AW-1:0] : a_top[AW-1:0];

  dqsb_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(value),
    .rd_en  (cmd.rd_en),
    .rd_addr(cursor[AW-1:0]),
    .rd_data(rd_data)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= in_opcode;
      value <= in_value;
    end
  end

  // list and pop cursor
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cursor <= sel_b ? head_b : head_a;
    end else if (cmd.advance) begin
      cursor <= sel_b ? (cursor - PTR_ONE) : (cursor + PTR_ONE);
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      head_a  <= '0;
      tail_a  <= '0;
      head_b  <= PTR_END;
      tail_b  <= PTR_END;
    end else if (cmd.push) begin
      if (sel_b) begin
        if (b_empty) begin
          head_b <= PTR_TOP;
        end
        tail_b <= b_tail_new;
      end else begin
        if (!a_valid) begin
          head_a <= '0;
        end
        a_valid <= 1'b1;
        tail_a  <= a_top;
      end
    end else if (cmd.load_data && kind == KIND_POP) begin
      if (sel_b) begin
        if (head_b == tail_b) begin
          head_b <= PTR_END;
          tail_b <= PTR_END;
        end else begin
          head_b <= head_b - PTR_ONE;
        end
      end else begin
        if (head_a == tail_a) begin
          a_valid <= 1'b0;
          head_a  <= '0;
          tail_a  <= '0;
        end else begin
          head_a <= head_a + PTR_ONE;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_value  <= '0;
      out_status <= ST_OK;
      out_last   <= 1'b1;
    end else if (cmd.fail) begin
      out_value  <= '0;
      out_status <= cmd.fail_status;
      out_last   <= 1'b1;
    end else if (cmd.load_data) begin
      out_value  <= rd_data;
      out_status <= ST_OK;
      out_last   <= (kind == KIND_POP) || (cursor == tail_sel);
    end
  end

endmodule

// ===== design/dual_queue_shared_buffer.sv =====
// dual_queue_shared_buffer: two linear queues sharing one buffer, top level
// depends on dqsb_pkg, dqsb_ctrl, dqsb_datapath and dqsb_ram
`timescale 1ns / 1ps

// channel   signals                      payload
// s_*       s_tvalid s_tready            s_tuser opcode, s_tdata push_value
// m_*       m_tvalid m_tready m_tlast    m_tdata item_value, m_tuser status
//
// one request at a time; the buffer ram has a registered read port
// push or error result: the request is captured, then decided, then offered on m_*
// pop or list: each item is one ram read, then offered; a list steps front to rear
// rst clears the pointers and the controller state only, buffer contents are unknown until written
// while a result waits on m_tready no new request is taken

module dual_queue_shared_buffer #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] item_value
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);
  import dqsb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dqsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dqsb_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_opcode (s_tuser),
    .in_value  (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_value (m_tdata),
    .out_status(m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// ===== tb/tb_dual_queue_shared_buffer.sv =====
// tb_dual_queue_shared_buffer: self-checking bench for the dual queue shared buffer
// drives requests on the s_* stream and checks results on the m_* stream
// depends on dqsb_pkg and dual_queue_shared_buffer
`timescale 1ns / 1ps

module tb_dual_queue_shared_buffer;
  import dqsb_pkg::*;

  localparam int DEPTH       = 16;
  localparam int N_RANDOM    = 140;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 27;

  // opcodes the block ignores
  localparam logic [2:0] OP_NOP_6 = 3'd6;
  localparam logic [2:0] OP_NOP_7 = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic        last;
  } qresult_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] value;
    bit          typed;
    logic [31:0] want_value;
    status_t     want_status;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] push_value
  logic [2:0]  s_tuser = '0;   // [2:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] item_value
  logic [1:0]  m_tuser;        // [1:0] status
  logic        m_tlast;

  // shadow copy of the queues
  logic [31:0] shadow_buf [DEPTH];
  int          a_head = 0;
  int          a_tail = 0;
  bit          a_live = 1'b0;
  int          b_head = DEPTH;
  int          b_tail = DEPTH;

  qresult_t    pending_results [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_ask = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;

  dual_queue_shared_buffer #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic qresult_t mk_result(input logic [31:0] value, input status_t st,
                                         input logic last);
    qresult_t r;
    r.value  = value;
    r.status = st;
    r.last   = last;
    return r;
  endfunction

  // apply one request to the shadow queues, queue its results, return how many
  function automatic int predict_queue_op(input logic [2:0] op, input logic [31:0] val);
    bit is_full;
    int n;
    is_full = ((a_live ? a_tail + 1 : 0) >= ((b_head >= DEPTH) ? DEPTH : b_tail));
    n = 0;
    case (op)
      OP_PUSH_A: begin
        if (is_full) begin
          pending_results.push_back(mk_result('0, ST_OVERFLOW, 1'b1));
        end else begin
          if (!a_live) begin
            a_head = 0;
            a_tail = 0;
            a_live = 1'b1;
          end else begin
            a_tail++;
          end
          shadow_buf[a_tail] = val;
          pending_results.push_back(mk_result('0, ST_OK, 1'b1));
        end
        n = 1;
      end
      OP_PUSH_B: begin
        if (is_full) begin
          pending_results.push_back(mk_result('0, ST_OVERFLOW, 1'b1));
        end else begin
          if (b_head >= DEPTH) begin
            b_head = DEPTH - 1;
            b_tail = DEPTH - 1;
          end else begin
            b_tail--;
          end
          shadow_buf[b_tail] = val;
          pending_results.push_back(mk_result('0, ST_OK, 1'b1));
        end
        n = 1;
      end
      OP_POP_A: begin
        if (!a_live) begin
          pending_results.push_back(mk_result('0, ST_UNDERFLOW, 1'b1));
        end else begin
          pending_results.push_back(mk_result(shadow_buf[a_head], ST_OK, 1'b1));
          a_head++;
          // last item gone: back to empty
          if (a_head > a_tail) begin
            a_head = 0;
            a_tail = 0;
            a_live = 1'b0;
          end
        end
        n = 1;
      end
      OP_POP_B: begin
        if (b_head >= DEPTH) begin
          pending_results.push_back(mk_result('0, ST_UNDERFLOW, 1'b1));
        end else begin
          pending_results.push_back(mk_result(shadow_buf[b_head], ST_OK, 1'b1));
          b_head--;
          if (b_head < b_tail) begin
            b_head = DEPTH;
            b_tail = DEPTH;
          end
        end
        n = 1;
      end
      OP_LIST_A: begin
        if (!a_live) begin
          pending_results.push_back(mk_result('0, ST_UNDERFLOW, 1'b1));
          n = 1;
        end else begin
          for (int i = a_head; i <= a_tail; i++) begin
            pending_results.push_back(mk_result(shadow_buf[i], ST_OK, i == a_tail));
            n++;
          end
        end
      end
      OP_LIST_B: begin
        if (b_head >= DEPTH) begin
          pending_results.push_back(mk_result('0, ST_UNDERFLOW, 1'b1));
          n = 1;
        end else begin
          for (int i = b_head; i >= b_tail; i--) begin
            pending_results.push_back(mk_result(shadow_buf[i], ST_OK, i == b_tail));
            n++;
          end
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    qresult_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result data=%h status=%0d last=%b",
                              m_tdata, m_tuser, m_tlast));
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata !== want.value)
      flag_mismatch($sformatf("item_value %h, want %h", m_tdata, want.value));
    if (m_tuser !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
    if (m_tlast !== want.last)
      flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
  endtask

  // result side: random ready, one long hold-off, checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (hold_ask && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        m_tready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // offer one request until taken, then predict its results
  task automatic issue_request(input logic [2:0] op, input logic [31:0] val,
                               output int n_new);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_new = predict_queue_op(op, val);
  endtask

  // operation mix per phase: drain, fill, mixed
  function automatic logic [2:0] pick_opcode(input int bias);
    int w [6];
    logic [2:0] ops [6];
    int r;
    ops = '{OP_PUSH_A, OP_PUSH_B, OP_POP_A, OP_POP_B, OP_LIST_A, OP_LIST_B};
    case (bias)
      0:       w = '{8, 8, 30, 30, 10, 10};
      1:       w = '{40, 40, 6, 6, 3, 3};
      default: w = '{22, 22, 18, 18, 8, 8};
    endcase
    r = $urandom_range(0, 99);
    for (int k = 0; k < 6; k++) begin
      if (r < w[k]) return ops[k];
      r -= w[k];
    end
    return ($urandom_range(0, 1) != 0) ? OP_NOP_7 : OP_NOP_6;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // directed plan: empty queues, unused opcode, extremes, fill to full, overflow, lists
  plan_row_t plan [N_DIRECTED] = '{
    '{OP_POP_A,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_LIST_B, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_NOP_7,  32'hdead_beef, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_POP_B,  32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK},
    '{OP_POP_B,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_LIST_A, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDERFLOW},
    '{OP_PUSH_A, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'haaaa_aaaa, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h7fff_fffe, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'hfedc_ba98, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h0f0f_0f0f, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'hf0f0_f0f0, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_B, 32'h3c3c_c3c3, 1'b1, 32'h0000_0000, ST_OK},
    '{OP_PUSH_A, 32'h0bad_f00d, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    '{OP_PUSH_B, 32'h0bad_f00d, 1'b1, 32'h0000_0000, ST_OVERFLOW},
    '{OP_LIST_A, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{OP_LIST_B, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
  };

  // request side
  initial begin
    int          n_new;
    int          counted;
    bit          drained;
    logic [2:0]  op;
    logic [31:0] val;
    counted = 0;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed rows replace the predicted result
    for (int k = 0; k < N_DIRECTED; k++) begin
      issue_request(plan[k].op, plan[k].value, n_new);
      if (plan[k].typed) begin
        repeat (n_new) void'(pending_results.pop_back());
        pending_results.push_back(mk_result(plan[k].want_value, plan[k].want_status,
                                            1'b1));
      end
    end

    // random phases of drain, fill and mixed traffic
    while (counted < N_RANDOM) begin
      calm = (counted >= 60 && counted < 100);
      if (counted == 30) hold_ask = 1'b1;
      if (counted == 120 && !drained) begin
        drained = 1'b1;
        if (pending_results.size() != 0) begin
          s_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      op  = pick_opcode((counted / 16) % 3);
      val = pick_value();
      issue_request(op, val, n_new);
      if (op != OP_NOP_6 && op != OP_NOP_7) counted++;
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // wait out the remaining results, then let the bench idle before the verdict
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
